[rtl/bvf_pkg.sv]
// ----------------------------------------------------------------------------
// bvf_pkg
// Format codes and field layout shared by the compressed block flip logic.
// ----------------------------------------------------------------------------
package bvf_pkg;

    // Block half and register widths
    localparam int unsigned HALF_W   = 64;
    localparam int unsigned MODE_W   = 3;

    // Layout of the 3-bit index grid of the alpha half (bits 16..63)
    localparam int unsigned GRID_LSB = 16;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned ROWS     = 4;

    // Format codes; the two unused codes pass the block unchanged
    typedef enum logic [MODE_W-1:0] {
        MODE_DXT1 = 3'd0,
        MODE_DXT3 = 3'd1,
        MODE_DXT5 = 3'd2,
        MODE_BC4  = 3'd3,
        MODE_BC5  = 3'd4,
        MODE_PASS = 3'd5
    } t_format_mode;

    typedef logic [HALF_W-1:0] t_half;

endpackage

[rtl/bcn_block_vertical_flip.sv]
// ----------------------------------------------------------------------------
// bcn_block_vertical_flip
// Mirrors one compressed 4x4 texel block top to bottom per configured format.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one 16-byte block as
//   i_block_low (bytes 0..7) and i_block_high (bytes 8..15). The output
//   channel (o_out_valid / i_out_stall) returns the flipped block on
//   o_flipped_low / o_flipped_high, one result word per input word, in order.
//   The user must set the format (i_cfg_valid / o_cfg_ready / i_cfg_data) while
//   no word is in flight; the block has no check. The port is always ready.
// Timing:
//   Two register stages: an input register, the byte/row permutation, and a
//   result register. An accepted word moves from the input register through
//   the permutation into the result register, which drives o_out_valid, and one
//   word is accepted every cycle while the receiver keeps i_out_stall low.
// Reset and stall:
//   Reset empties both stages and sets the format to DXT1. When the receiver
//   stalls, the result register holds its word and the input register still
//   takes one more word; o_in_stall rises only once both stages are full.
// ----------------------------------------------------------------------------
module bcn_block_vertical_flip (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bvf_pkg::MODE_W-1:0] i_cfg_data,
    // Input word
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  bvf_pkg::t_half             i_block_low,
    input  bvf_pkg::t_half             i_block_high,
    // Result word
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output bvf_pkg::t_half             o_flipped_low,
    output bvf_pkg::t_half             o_flipped_high
);

    logic [bvf_pkg::MODE_W-1:0] r_format_mode;

    logic                       r_in_valid;
    bvf_pkg::t_half             r_in_low;
    bvf_pkg::t_half             r_in_high;

    logic                       r_out_valid;
    bvf_pkg::t_half             r_out_low;
    bvf_pkg::t_half             r_out_high;

    bvf_pkg::t_half             n_out_low;
    bvf_pkg::t_half             n_out_high;

    logic                       out_adv;
    logic                       in_take;

    // Stage handshake: result stage frees when empty or taken downstream
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_take    = !r_in_valid || out_adv;
    assign o_in_stall = !in_take;
    assign o_cfg_ready = 1'b1;

    // Hold the format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= bvf_pkg::MODE_DXT1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_format_mode <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in_low  <= i_block_low;
            r_in_high <= i_block_high;
        end
    end

    // Permute the registered word
    bvf_permute u_permute (
        .i_format_mode  (r_format_mode),
        .i_block_low    (r_in_low),
        .i_block_high   (r_in_high),
        .o_flipped_low  (n_out_low),
        .o_flipped_high (n_out_high)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_out_low  <= n_out_low;
            r_out_high <= n_out_high;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_flipped_low  = r_out_low;
    assign o_flipped_high = r_out_high;

    // Assertions

    // Stall upstream only with both stages full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled while a stage is free");

    // A word moving forward lands in the result stage
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_in_valid) |=> r_out_valid)
        else $error("word lost between stages");

    // Pass-through leaves the word unchanged
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_in_valid && r_format_mode == bvf_pkg::MODE_PASS) |=>
        (o_flipped_low == $past(r_in_low) && o_flipped_high == $past(r_in_high)))
        else $error("pass-through altered the block");

    // Endpoints in bytes 0..1 survive every format but DXT3
    a_endpoints: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_in_valid && r_format_mode != bvf_pkg::MODE_DXT3) |=>
        (o_flipped_low[15:0] == $past(r_in_low[15:0])))
        else $error("endpoint bytes changed");

endmodule

[rtl/bvf_permute.sv]
// ----------------------------------------------------------------------------
// bvf_permute
// Combinational row reversal of one 16-byte block for the selected format.
// ----------------------------------------------------------------------------
module bvf_permute (
    input  logic [bvf_pkg::MODE_W-1:0] i_format_mode,
    input  bvf_pkg::t_half             i_block_low,
    input  bvf_pkg::t_half             i_block_high,
    output bvf_pkg::t_half             o_flipped_low,
    output bvf_pkg::t_half             o_flipped_high
);

    // Reverse bytes 4..7, one colour index byte per texel row
    function automatic bvf_pkg::t_half rev_upper_bytes(input bvf_pkg::t_half w);
        return {w[39:32], w[47:40], w[55:48], w[63:56], w[31:0]};
    endfunction

    // Reverse the four 16-bit explicit alpha rows
    function automatic bvf_pkg::t_half rev_u16_rows(input bvf_pkg::t_half w);
        return {w[15:0], w[31:16], w[47:32], w[63:48]};
    endfunction

    // Reverse the four 12-bit rows of the 3-bit index grid, keep the endpoints
    function automatic bvf_pkg::t_half rev_grid_rows(input bvf_pkg::t_half w);
        bvf_pkg::t_half o;
        o = w;
        for (int r = 0; r < bvf_pkg::ROWS; r++) begin
            o[bvf_pkg::GRID_LSB + bvf_pkg::ROW_W*(bvf_pkg::ROWS-1-r) +: bvf_pkg::ROW_W] =
                w[bvf_pkg::GRID_LSB + bvf_pkg::ROW_W*r +: bvf_pkg::ROW_W];
        end
        return o;
    endfunction

    // Select the rule for each half
    always_comb begin
        o_flipped_low  = i_block_low;
        o_flipped_high = i_block_high;
        case (i_format_mode)
            bvf_pkg::MODE_DXT1: begin
                o_flipped_low  = rev_upper_bytes(i_block_low);
            end
            bvf_pkg::MODE_DXT3: begin
                o_flipped_low  = rev_u16_rows(i_block_low);
                o_flipped_high = rev_upper_bytes(i_block_high);
            end
            bvf_pkg::MODE_DXT5: begin
                o_flipped_low  = rev_grid_rows(i_block_low);
                o_flipped_high = rev_upper_bytes(i_block_high);
            end
            bvf_pkg::MODE_BC4: begin
                o_flipped_low  = rev_grid_rows(i_block_low);
            end
            bvf_pkg::MODE_BC5: begin
                o_flipped_low  = rev_grid_rows(i_block_low);
                o_flipped_high = rev_grid_rows(i_block_high);
            end
            default: begin
                o_flipped_low  = i_block_low;
                o_flipped_high = i_block_high;
            end
        endcase
    end

endmodule
